// ===== design/msfl_pkg.sv =====
// package: shared codes and constants of the shared free list stack unit
`default_nettype none

package msfl_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned StackIdWidth = 2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam logic [ValueWidth-1:0] MOST_NEG = {1'b1, {(ValueWidth-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage

`default_nettype wire

// ===== design/msfl_link_store.sv =====
// link memory with fill mark that supplies the reset chain for untouched entries
`default_nettype none

module msfl_link_store #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW      = 4,
  parameter int unsigned PW      = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [IW-1:0] rd_addr_i,
  output logic      [PW-1:0] rd_link_o,
  input  wire logic          wr_en_i,
  input  wire logic [IW-1:0] wr_addr_i,
  input  wire logic [PW-1:0] wr_link_i
);

  logic [PW-1:0] mem [ENTRIES];
  logic [PW-1:0] rdata_q;
  logic [PW-1:0] next_q;
  logic          fresh_q;
  logic [PW-1:0] fill_q, fill_d;

  // entries at or above the fill mark were never written
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
      next_q  <= PW'(rd_addr_i) + PW'(1);
    end
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_link_i;
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && (PW'(wr_addr_i) == fill_q)) begin
      fill_d = fill_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      fresh_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (rd_en_i) begin
        fresh_q <= (PW'(rd_addr_i) >= fill_q);
      end
    end
  end

  assign rd_link_o = fresh_q ? next_q : rdata_q;

endmodule

`default_nettype wire

// ===== design/multi_stack_shared_free_list_unit.sv =====
// top level: several stacks sharing one data memory through a linked free list
//
// channel   direction  ports                                   handshake
// command   in         mode_i, stack_id_i, push_value_i        start_i && !busy_o
// result    out        pop_value_o, status_o                   done_o, one cycle
//
// per word, the accept cycle reads the link memory and, for a pop, the data memory;
// the next cycle (busy_o high) uses the read data and writes pointers back.
// the result shows in the cycle after, while a new word may already be taken.
// reset sets every stack empty and the free list to all entries in order; a fill
// mark stands in for the link chain, so no clearing pass is needed.
// the receiver cannot stall, so results are never held back.
`default_nettype none

module multi_stack_shared_free_list_unit
  import msfl_pkg::*;
#(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned STACK_COUNT = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic                   mode_i,
  input  wire logic [StackIdWidth-1:0] stack_id_i,
  input  wire logic [ValueWidth-1:0]  push_value_i,
  output logic                        done_o,
  output logic      [ValueWidth-1:0]  pop_value_o,
  output logic      [1:0]             status_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned PW = $clog2(ENTRIES + 1);
  localparam int unsigned SW = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

  state_e state_q, state_d;

  logic [PW-1:0] tops_q [STACK_COUNT];
  logic [PW-1:0] free_head_q;

  logic                  mode_q;
  logic [SW-1:0]         tid_q;
  logic [ValueWidth-1:0] val_q;
  logic [PW-1:0]         slot_q;
  logic                  ok_q;

  logic                  done_q;
  logic [ValueWidth-1:0] pop_value_q;
  status_e               status_q;

  logic [ValueWidth-1:0] data_mem [ENTRIES];
  logic [ValueWidth-1:0] data_rd_q;

  logic          accept;
  logic          sid_ok;
  logic [SW-1:0] tid;
  logic [PW-1:0] slot;
  logic          slot_ok;
  logic          exec;
  logic [PW-1:0] link;
  logic          lnk_wr_en;
  logic [PW-1:0] lnk_wr_data;

  assign busy_o  = (state_q == S_EXEC);
  assign exec    = busy_o;
  assign accept  = start_i && !busy_o;
  assign sid_ok  = (32'(stack_id_i) < STACK_COUNT);
  assign tid     = SW'(stack_id_i);
  assign slot    = (mode_i == MODE_PUSH) ? free_head_q
                 : (sid_ok ? tops_q[tid] : NULL_PTR);
  assign slot_ok = sid_ok && (slot < NULL_PTR);

  assign lnk_wr_en   = exec && ok_q;
  assign lnk_wr_data = (mode_q == MODE_PUSH) ? tops_q[tid_q] : free_head_q;

  msfl_link_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW),
    .PW      (PW)
  ) u_link (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && slot_ok),
    .rd_addr_i (slot[IW-1:0]),
    .rd_link_o (link),
    .wr_en_i   (lnk_wr_en),
    .wr_addr_i (slot_q[IW-1:0]),
    .wr_link_i (lnk_wr_data)
  );

  // data memory, no reset
  always_ff @(posedge clk_i) begin
    if (accept && slot_ok && (mode_i == MODE_POP)) begin
      data_rd_q <= data_mem[slot[IW-1:0]];
    end
    if (exec && ok_q && (mode_q == MODE_PUSH)) begin
      data_mem[slot_q[IW-1:0]] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      tid_q  <= tid;
      val_q  <= push_value_i;
      slot_q <= slot;
      ok_q   <= slot_ok;
    end
    if (exec) begin
      if (mode_q == MODE_PUSH) begin
        pop_value_q <= '0;
        status_q    <= ok_q ? ST_OK : ST_OVERFLOW;
      end else begin
        pop_value_q <= ok_q ? data_rd_q : MOST_NEG;
        status_q    <= ok_q ? ST_OK : ST_UNDERFLOW;
      end
    end
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = accept ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      done_q      <= 1'b0;
      free_head_q <= '0;
      for (int i = 0; i < int'(STACK_COUNT); i++) begin
        tops_q[i] <= NULL_PTR;
      end
    end else begin
      state_q <= state_d;
      done_q  <= exec;
      if (exec && ok_q) begin
        if (mode_q == MODE_PUSH) begin
          free_head_q   <= link;
          tops_q[tid_q] <= slot_q;
        end else begin
          tops_q[tid_q] <= link;
          free_head_q   <= slot_q;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign pop_value_o = pop_value_q;
  assign status_o    = status_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted word did not enter execution");

  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (!busy_o && done_o))
    else $error("execution did not finish with a result in one cycle");

  a_done_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without execution");

  a_free_not_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q == NULL_PTR) || (free_head_q != tops_q[0]))
    else $error("free list head is also a stack top");

endmodule

`default_nettype wire
